// File: hdl/pgrs_pkg.sv
// Shared types and constants for the per-group request serializer.
// Used by pgrs_table and per_group_request_serializer_unit; no dependencies.
`timescale 1ns / 1ps

package pgrs_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam logic [6:0]  MAX_TRIES_RESET   = 7'd100;
    localparam logic [15:0] RETRY_DELAY_RESET = 16'd3000;

    typedef enum logic [1:0] {
        OP_REQUEST  = 2'd0,
        OP_CANCEL   = 2'd1,
        OP_RESPONSE = 2'd2,
        OP_UNUSED   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_REQUEST_ENABLE = 2'd0,
        REG_CANCEL_ENABLE  = 2'd1,
        REG_MAX_TRIES      = 2'd2,
        REG_RETRY_DELAY    = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [31:0] id;
        logic [7:0]  group;
        logic [31:0] handle;
        logic [62:0] stamp;
        logic [31:0] order;
    } entry_t;

    // Table write command: insert, try-count update or slot release.
    typedef struct packed {
        logic       insert;
        logic       set_tries;
        logic       release_slot;
        logic [6:0] tries;
        entry_t     entry;
    } tbl_cmd_t;

endpackage

// File: hdl/pgrs_table.sv
// Request table: entry and try-count memories with registered read,
// valid bits in flops. Depends on pgrs_pkg.
`timescale 1ns / 1ps

module pgrs_table #(
    parameter int DEPTH = pgrs_pkg::DEPTH_DEFAULT,
    localparam int IDX_W = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [IDX_W-1:0]     rd_addr,
    output pgrs_pkg::entry_t     rd_entry,
    output logic [6:0]           rd_tries,
    output logic                 rd_valid,
    input  logic [IDX_W-1:0]     wr_idx,
    input  pgrs_pkg::tbl_cmd_t   cmd
);
    import pgrs_pkg::*;

    entry_t     entry_mem [DEPTH];
    logic [6:0] tries_mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            entry_mem[wr_idx] <= cmd.entry;
        end
        rd_entry <= entry_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.insert || cmd.set_tries)
        begin
            tries_mem[wr_idx] <= cmd.tries;
        end
        rd_tries <= tries_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_valid  <= 1'b0;
        end
        else
        begin
            rd_valid <= valid_reg[rd_addr];
            if (cmd.insert)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            else if (cmd.release_slot)
            begin
                valid_reg[wr_idx] <= 1'b0;
            end
        end
    end

endmodule

// File: hdl/per_group_request_serializer_unit.sv
// Top level of the per-group request serializer: sequencer, scan compare
// unit and stream ports. Depends on pgrs_pkg and pgrs_table.
`timescale 1ns / 1ps

// One input transfer is taken at a time and yields an optional issue transfer followed by a
// completion transfer (tlast high). The sequencer walks the table one entry per cycle through
// a single compare unit fed by the table's one read port: every operation that touches the
// table makes a lookup pass over all entries followed by a decision step, and a removal of an
// active entry adds a promotion pass with its own decision step before the output transfers.
// A request with requests disabled, a disabled cancel or an unused op skips the table and
// goes straight to the completion transfer.
// Configuration writes are always taken and apply at once.
module per_group_request_serializer_unit #(
    parameter int TABLE_DEPTH = pgrs_pkg::DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    // group[7:0], req_id[39:8], payload_handle[71:40], sched_time[135:72],
    // now[198:136], failed[199]
    input  logic [199:0]  s_tdata,
    // op[1:0]
    input  logic [1:0]    s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // issue_id[31:0], issue_handle[63:32], issue_time[127:64], retry_taken[128],
    // cancel_forwarded[129], dropped[130], zero[135:131]
    output logic [135:0]  m_tdata,
    // kind[0]
    output logic          m_tuser,
    output logic          m_tlast,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [15:0]   cfg_data
);
    import pgrs_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_SCAN1  = 10'b0000000010,
        ST_END1   = 10'b0000000100,
        ST_DEC1   = 10'b0000001000,
        ST_REMOVE = 10'b0000010000,
        ST_SCAN2  = 10'b0000100000,
        ST_END2   = 10'b0001000000,
        ST_DEC2   = 10'b0010000000,
        ST_ISSUE  = 10'b0100000000,
        ST_DONE   = 10'b1000000000
    } state_t;

    state_t state_reg;

    logic        req_en_reg;
    logic        can_en_reg;
    logic [6:0]  max_tries_reg;
    logic [15:0] retry_delay_reg;
    logic [31:0] insert_cnt_reg;

    op_t         op_reg;
    logic [7:0]  grp_reg;
    logic [31:0] id_reg;
    logic [31:0] hdl_reg;
    logic [63:0] sched_reg;
    logic [62:0] now_reg;
    logic        failed_reg;

    logic [IDX_W-1:0] cnt_reg;
    logic             ev_reg;
    logic [IDX_W-1:0] ev_idx_reg;

    logic             free_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic             busy_reg;
    logic             hit_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [31:0]      hit_age_reg;
    entry_t           hit_ent_reg;
    logic [6:0]       hit_tries_reg;
    logic             pick_reg;
    logic [IDX_W-1:0] pick_idx_reg;
    logic [31:0]      pick_age_reg;
    entry_t           pick_ent_reg;

    logic [31:0] iss_id_reg;
    logic [31:0] iss_hdl_reg;
    logic [63:0] iss_time_reg;
    logic        retry_reg;
    logic        cfwd_reg;
    logic        drop_reg;

    entry_t           rd_entry;
    logic [6:0]       rd_tries;
    logic             rd_valid;
    logic [IDX_W-1:0] wr_idx;
    tbl_cmd_t         cmd;

    logic        scanning;
    logic        phase2;
    logic [31:0] age;
    logic [63:0] retry_sum;
    logic [63:0] retry_time;
    logic        s_fire;

    pgrs_table #(.DEPTH(TABLE_DEPTH)) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_addr  (cnt_reg),
        .rd_entry (rd_entry),
        .rd_tries (rd_tries),
        .rd_valid (rd_valid),
        .wr_idx   (wr_idx),
        .cmd      (cmd)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign scanning  = (state_reg == ST_SCAN1) || (state_reg == ST_SCAN2);
    assign phase2    = (state_reg == ST_SCAN2) || (state_reg == ST_END2);
    assign age       = insert_cnt_reg - rd_entry.order;
    assign retry_sum = {1'b0, now_reg} + {48'd0, retry_delay_reg};
    assign retry_time = retry_sum[63] ? {1'b0, {63{1'b1}}} : retry_sum;

    assign m_tvalid = (state_reg == ST_ISSUE) || (state_reg == ST_DONE);
    assign m_tuser  = (state_reg == ST_DONE);
    assign m_tlast  = (state_reg == ST_DONE);
    always_comb
    begin
        if (state_reg == ST_DONE)
        begin
            m_tdata = {5'd0, drop_reg, cfwd_reg, retry_reg, 128'd0};
        end
        else
        begin
            m_tdata = {8'd0, iss_time_reg, iss_hdl_reg, iss_id_reg};
        end
    end

    // Table write port, driven only in the decision and removal steps.
    always_comb
    begin
        cmd = '0;
        wr_idx = hit_idx_reg;
        cmd.entry.id     = id_reg;
        cmd.entry.group  = grp_reg;
        cmd.entry.handle = hdl_reg;
        cmd.entry.stamp  = now_reg;
        cmd.entry.order  = insert_cnt_reg;
        cmd.tries        = hit_tries_reg + 7'd1;
        case (state_reg)
            ST_DEC1:
            begin
                if (op_reg == OP_REQUEST)
                begin
                    wr_idx = free_idx_reg;
                    cmd.insert = free_reg;
                    cmd.tries = busy_reg ? 7'd0 : 7'd1;
                end
                else if (op_reg == OP_RESPONSE)
                begin
                    cmd.set_tries = hit_reg && failed_reg && (hit_tries_reg < max_tries_reg);
                end
            end
            ST_REMOVE:
            begin
                cmd.release_slot = 1'b1;
            end
            ST_DEC2:
            begin
                wr_idx = pick_idx_reg;
                cmd.set_tries = pick_reg;
                cmd.tries = 7'd1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_en_reg      <= 1'b0;
            can_en_reg      <= 1'b0;
            max_tries_reg   <= MAX_TRIES_RESET;
            retry_delay_reg <= RETRY_DELAY_RESET;
        end
        else if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_REQUEST_ENABLE: req_en_reg      <= cfg_data[0];
                REG_CANCEL_ENABLE:  can_en_reg      <= cfg_data[0];
                REG_MAX_TRIES:      max_tries_reg   <= cfg_data[6:0];
                REG_RETRY_DELAY:    retry_delay_reg <= cfg_data;
                default:            req_en_reg      <= req_en_reg;
            endcase
        end
    end

    // Compare unit: one table entry per cycle, evaluated in the cycle after its address.
    always_ff @(posedge clk)
    begin
        ev_idx_reg <= cnt_reg;
        if (state_reg == ST_DEC1)
        begin
            pick_reg <= 1'b0;
        end
        if (state_reg == ST_IDLE)
        begin
            free_reg <= 1'b0;
            busy_reg <= 1'b0;
            hit_reg  <= 1'b0;
        end
        else if (ev_reg && !phase2)
        begin
            if (!rd_valid && !free_reg)
            begin
                free_reg     <= 1'b1;
                free_idx_reg <= ev_idx_reg;
            end
            if (rd_valid && rd_entry.group == grp_reg && rd_tries != 7'd0)
            begin
                busy_reg <= 1'b1;
            end
            if (rd_valid && rd_entry.id == id_reg && (!hit_reg || age < hit_age_reg))
            begin
                hit_reg       <= 1'b1;
                hit_idx_reg   <= ev_idx_reg;
                hit_age_reg   <= age;
                hit_ent_reg   <= rd_entry;
                hit_tries_reg <= rd_tries;
            end
        end
        else if (ev_reg && phase2)
        begin
            if (rd_valid && rd_entry.group == hit_ent_reg.group && rd_tries == 7'd0 &&
                (!pick_reg || rd_entry.stamp < pick_ent_reg.stamp ||
                 (rd_entry.stamp == pick_ent_reg.stamp && age > pick_age_reg)))
            begin
                pick_reg     <= 1'b1;
                pick_idx_reg <= ev_idx_reg;
                pick_age_reg <= age;
                pick_ent_reg <= rd_entry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            op_reg     <= op_t'(s_tuser);
            grp_reg    <= s_tdata[7:0];
            id_reg     <= s_tdata[39:8];
            hdl_reg    <= s_tdata[71:40];
            sched_reg  <= s_tdata[135:72];
            now_reg    <= s_tdata[198:136];
            failed_reg <= s_tdata[199];
        end
        if (state_reg == ST_DEC1)
        begin
            if (op_reg == OP_REQUEST)
            begin
                iss_id_reg   <= id_reg;
                iss_hdl_reg  <= hdl_reg;
                iss_time_reg <= sched_reg;
            end
            else
            begin
                iss_id_reg   <= hit_ent_reg.id;
                iss_hdl_reg  <= hit_ent_reg.handle;
                iss_time_reg <= retry_time;
            end
        end
        else if (state_reg == ST_DEC2)
        begin
            iss_id_reg   <= pick_ent_reg.id;
            iss_hdl_reg  <= pick_ent_reg.handle;
            iss_time_reg <= {1'b0, now_reg};
        end
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            insert_cnt_reg <= '0;
            cnt_reg        <= '0;
            ev_reg         <= 1'b0;
            retry_reg      <= 1'b0;
            cfwd_reg       <= 1'b0;
            drop_reg       <= 1'b0;
        end
        else
        begin
            ev_reg <= scanning;
            if (scanning)
            begin
                cnt_reg <= cnt_reg + IDX_W'(1);
            end
            else
            begin
                cnt_reg <= '0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_fire)
                    begin
                        retry_reg <= 1'b0;
                        drop_reg  <= 1'b0;
                        cfwd_reg  <= 1'b0;
                        case (op_t'(s_tuser))
                            OP_REQUEST:  state_reg <= req_en_reg ? ST_SCAN1 : ST_DONE;
                            OP_CANCEL:   state_reg <= can_en_reg ? ST_SCAN1 : ST_DONE;
                            OP_RESPONSE: state_reg <= ST_SCAN1;
                            default:     state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_SCAN1:
                begin
                    if (cnt_reg == LAST_IDX)
                    begin
                        state_reg <= ST_END1;
                    end
                end
                ST_END1:
                begin
                    state_reg <= ST_DEC1;
                end
                ST_DEC1:
                begin
                    case (op_reg)
                        OP_REQUEST:
                        begin
                            if (!free_reg)
                            begin
                                drop_reg  <= 1'b1;
                                state_reg <= ST_DONE;
                            end
                            else
                            begin
                                insert_cnt_reg <= insert_cnt_reg + 32'd1;
                                state_reg <= busy_reg ? ST_DONE : ST_ISSUE;
                            end
                        end
                        OP_CANCEL:
                        begin
                            cfwd_reg  <= 1'b1;
                            state_reg <= hit_reg ? ST_REMOVE : ST_DONE;
                        end
                        default:
                        begin
                            if (!hit_reg)
                            begin
                                state_reg <= ST_DONE;
                            end
                            else if (!failed_reg || hit_tries_reg >= max_tries_reg)
                            begin
                                state_reg <= ST_REMOVE;
                            end
                            else
                            begin
                                retry_reg <= 1'b1;
                                state_reg <= ST_ISSUE;
                            end
                        end
                    endcase
                end
                ST_REMOVE:
                begin
                    // a queued entry leaves without promoting anyone
                    state_reg <= (hit_tries_reg == 7'd0) ? ST_DONE : ST_SCAN2;
                end
                ST_SCAN2:
                begin
                    if (cnt_reg == LAST_IDX)
                    begin
                        state_reg <= ST_END2;
                    end
                end
                ST_END2:
                begin
                    state_reg <= ST_DEC2;
                end
                ST_DEC2:
                begin
                    state_reg <= pick_reg ? ST_ISSUE : ST_DONE;
                end
                ST_ISSUE:
                begin
                    if (m_tready)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (m_tready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: bench/tb_per_group_request_serializer_unit.sv
// Self-checking bench for per_group_request_serializer_unit: stream stimulus through
// an item queue, a table predictor and an in-order result check. Depends on pgrs_pkg.
`timescale 1ns / 1ps

module tb_per_group_request_serializer_unit;
    import pgrs_pkg::*;

    localparam int DEPTH = 16;
    localparam longint unsigned T_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic        failed;
        logic [62:0] now;
        logic [63:0] sched;
        logic [31:0] handle;
        logic [31:0] id;
        logic [7:0]  group;
        op_t         op;
    } req_item_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] id;
        logic [31:0] handle;
        logic [63:0] t;
        logic        retry;
        logic        cfwd;
        logic        drop;
        logic        last;
    } result_t;

    logic          clk;
    logic          rst_n;
    logic          s_tvalid;
    logic          s_tready;
    logic [199:0]  s_tdata;
    logic [1:0]    s_tuser;
    logic          m_tvalid;
    logic          m_tready;
    logic [135:0]  m_tdata;
    logic          m_tuser;
    logic          m_tlast;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [1:0]    cfg_index;
    logic [15:0]   cfg_data;

    per_group_request_serializer_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // predictor state
    logic        p_req_en, p_cancel_en;
    logic [6:0]  p_max_tries;
    logic [15:0] p_retry_delay;
    logic        tbl_valid [DEPTH];
    logic [31:0] tbl_id    [DEPTH];
    logic [7:0]  tbl_group [DEPTH];
    logic [31:0] tbl_handle[DEPTH];
    logic [62:0] tbl_stamp [DEPTH];
    logic [6:0]  tbl_tries [DEPTH];
    logic [31:0] tbl_order [DEPTH];
    logic [31:0] ins_count;

    req_item_t pending_items[$];
    result_t   expected_results[$];
    int  errors = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    int  issues_seen = 0;
    int  cycles = 0;
    bit  idle_off = 0;
    int  src_gap = 0;
    int  snk_gap = 0;
    logic [31:0] live_ids[$];
    logic s_tready_q;

    initial
    begin
        clk = 0;
        forever
        begin
            #1 clk = 1;
            #1 clk = 0;
        end
    end

    function automatic result_t issue_of(logic [31:0] id, logic [31:0] h, logic [63:0] t);
        result_t r;
        r = '0;
        r.id = id;
        r.handle = h;
        r.t = t;
        return r;
    endfunction

    function automatic int newest_slot(logic [31:0] id);
        int hit;
        logic [31:0] best, age;
        hit = -1;
        best = 0;
        for (int i = 0; i < DEPTH; i++)
            if (tbl_valid[i] && tbl_id[i] == id)
            begin
                age = ins_count - tbl_order[i];
                if (hit < 0 || age < best)
                begin
                    hit = i;
                    best = age;
                end
            end
        return hit;
    endfunction

    // Drop newest entry of id; if active, promote oldest queued entry of its group.
    task automatic release_and_promote(logic [31:0] id, logic [62:0] now);
        int s, pick;
        logic [31:0] pick_age, age;
        s = newest_slot(id);
        pick = -1;
        pick_age = 0;
        if (s < 0)
            return;
        tbl_valid[s] = 0;
        if (tbl_tries[s] == 0)
            return;
        for (int i = 0; i < DEPTH; i++)
            if (tbl_valid[i] && tbl_group[i] == tbl_group[s] && tbl_tries[i] == 0)
            begin
                age = ins_count - tbl_order[i];
                if (pick < 0 || tbl_stamp[i] < tbl_stamp[pick] ||
                    (tbl_stamp[i] == tbl_stamp[pick] && age > pick_age))
                begin
                    pick = i;
                    pick_age = age;
                end
            end
        if (pick < 0)
            return;
        tbl_tries[pick] = 1;
        expected_results.push_back(issue_of(tbl_id[pick], tbl_handle[pick], {1'b0, now}));
    endtask

    task automatic predict_serializer(req_item_t it);
        result_t done;
        int s;
        logic busy;
        longint unsigned t;
        done = '0;
        done.kind = 1;
        done.last = 1;
        case (it.op)
            OP_REQUEST:
                if (p_req_en)
                begin
                    s = -1;
                    for (int i = 0; i < DEPTH; i++)
                        if (!tbl_valid[i] && s < 0)
                            s = i;
                    if (s < 0)
                        done.drop = 1;
                    else
                    begin
                        tbl_valid[s] = 1;
                        tbl_id[s] = it.id;
                        tbl_group[s] = it.group;
                        tbl_handle[s] = it.handle;
                        tbl_stamp[s] = it.now;
                        tbl_tries[s] = 0;
                        tbl_order[s] = ins_count;
                        ins_count++;
                        busy = 0;
                        for (int i = 0; i < DEPTH; i++)
                            if (tbl_valid[i] && tbl_group[i] == it.group && tbl_tries[i] != 0)
                                busy = 1;
                        if (!busy)
                        begin
                            tbl_tries[s] = 1;
                            expected_results.push_back(issue_of(it.id, it.handle, it.sched));
                        end
                    end
                end
            OP_CANCEL:
                if (p_cancel_en)
                begin
                    release_and_promote(it.id, it.now);
                    done.cfwd = 1;
                end
            OP_RESPONSE:
                if (!it.failed)
                    release_and_promote(it.id, it.now);
                else
                begin
                    s = newest_slot(it.id);
                    if (s >= 0)
                    begin
                        if (tbl_tries[s] >= p_max_tries)
                            release_and_promote(it.id, it.now);
                        else
                        begin
                            t = longint'(it.now) + p_retry_delay;
                            if (t > T_MAX)
                                t = T_MAX;
                            tbl_tries[s] = tbl_tries[s] + 7'd1;
                            expected_results.push_back(issue_of(tbl_id[s], tbl_handle[s], t));
                            done.retry = 1;
                        end
                    end
                end
            default: ;
        endcase
        expected_results.push_back(done);
    endtask

    // driver: inputs change on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!(s_tvalid && !s_tready_q))
            begin
                if (src_gap > 0)
                begin
                    src_gap <= src_gap - 1;
                    s_tvalid <= 0;
                end
                else if (pending_items.size() > 0 && !idle_off && $urandom_range(0, 7) == 0)
                begin
                    src_gap <= $urandom_range(0, 3);
                    s_tvalid <= 0;
                end
                else if (pending_items.size() > 0)
                begin
                    req_item_t it;
                    it = pending_items.pop_front();
                    s_tvalid <= 1;
                    s_tuser <= it.op;
                    s_tdata <= {it.failed, it.now, it.sched, it.handle, it.id, it.group};
                end
                else
                    s_tvalid <= 0;
            end
            if (snk_gap > 0)
            begin
                snk_gap <= snk_gap - 1;
                m_tready <= 0;
            end
            else if (!idle_off && $urandom_range(0, 6) == 0)
            begin
                snk_gap <= $urandom_range(0, 3);
                m_tready <= 0;
            end
            else
                m_tready <= 1;
        end
    end

    // a presented item is held until the block takes it
    always @(posedge clk)
        s_tready_q <= s_tvalid && !s_tready ? 1'b0 : 1'b1;

    // monitor: sample on the rising edge
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && s_tvalid && s_tready)
        begin
            req_item_t it;
            it = {s_tdata[199], s_tdata[198:136], s_tdata[135:72], s_tdata[71:40],
                  s_tdata[39:8], s_tdata[7:0], op_t'(s_tuser)};
            predict_serializer(it);
            items_sent <= items_sent + 1;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            result_t e;
            results_seen <= results_seen + 1;
            if (!m_tuser)
                issues_seen <= issues_seen + 1;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result kind=%0d", m_tuser);
                errors++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (m_tuser !== e.kind)
                begin
                    $error("kind exp %0d got %0d", e.kind, m_tuser);
                    errors++;
                end
                if (m_tdata[31:0] !== e.id)
                begin
                    $error("issue_id exp %h got %h", e.id, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[63:32] !== e.handle)
                begin
                    $error("issue_handle exp %h got %h", e.handle, m_tdata[63:32]);
                    errors++;
                end
                if (m_tdata[127:64] !== e.t)
                begin
                    $error("issue_time exp %h got %h", e.t, m_tdata[127:64]);
                    errors++;
                end
                if (m_tdata[128] !== e.retry)
                begin
                    $error("retry_taken exp %0d got %0d", e.retry, m_tdata[128]);
                    errors++;
                end
                if (m_tdata[129] !== e.cfwd)
                begin
                    $error("cancel_forwarded exp %0d got %0d", e.cfwd, m_tdata[129]);
                    errors++;
                end
                if (m_tdata[130] !== e.drop)
                begin
                    $error("dropped exp %0d got %0d", e.drop, m_tdata[130]);
                    errors++;
                end
                if (m_tlast !== e.last)
                begin
                    $error("last exp %0d got %0d", e.last, m_tlast);
                    errors++;
                end
            end
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** per_group_request_serializer_unit: FAILED **");
            $finish;
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_REQUEST_ENABLE: p_req_en = val[0];
            REG_CANCEL_ENABLE:  p_cancel_en = val[0];
            REG_MAX_TRIES:      p_max_tries = val[6:0];
            default:            p_retry_delay = val;
        endcase
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    task automatic drain;
        while (pending_items.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // queues one item; handle and schedule time are random, the rest is given
    task automatic add_item(op_t op, logic [7:0] grp, logic [31:0] id, logic [62:0] now,
                            logic failed);
        req_item_t it;
        it.op = op;
        it.group = grp;
        it.id = id;
        it.handle = $urandom;
        it.sched = {$urandom, $urandom};
        it.now = now;
        it.failed = failed;
        pending_items.push_back(it);
    endtask

    function automatic logic [31:0] pick_id();
        if (live_ids.size() > 0 && $urandom_range(0, 9) != 0)
            return live_ids[$urandom_range(0, live_ids.size() - 1)];
        return $urandom;
    endfunction

    task automatic random_phase(int n, int ngroups);
        logic [31:0] id;
        logic [62:0] now;
        int r;
        for (int k = 0; k < n; k++)
        begin
            now = 63'({$urandom, $urandom} >> 1);
            if ($urandom_range(0, 15) == 0)
                now = 63'h7FFF_FFFF_FFFF_FF00 + 63'($urandom_range(0, 255));
            else if ($urandom_range(0, 3) == 0)
                now = 63'($urandom_range(0, 20));
            r = $urandom_range(0, 99);
            if (r < 40)
            begin
                id = ($urandom_range(0, 9) == 0 && live_ids.size() > 0) ? pick_id() : $urandom;
                live_ids.push_back(id);
                if (live_ids.size() > 40)
                    void'(live_ids.pop_front());
                add_item(OP_REQUEST, 8'($urandom_range(0, ngroups - 1)), id, now, 1'b0);
            end
            else if (r < 55)
                add_item(OP_CANCEL, 8'($urandom), pick_id(), now, 1'b0);
            else if (r < 97)
                add_item(OP_RESPONSE, 8'($urandom), pick_id(), now,
                         1'($urandom_range(0, 1)));
            else
                add_item(OP_UNUSED, 8'($urandom), $urandom, now, 1'($urandom));
        end
    endtask

    initial
    begin
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 0;
        cfg_valid = 0;
        cfg_index = REG_REQUEST_ENABLE;
        cfg_data = '0;
        p_req_en = 0;
        p_cancel_en = 0;
        p_max_tries = MAX_TRIES_RESET;
        p_retry_delay = RETRY_DELAY_RESET;
        ins_count = 0;
        for (int i = 0; i < DEPTH; i++)
        begin
            tbl_valid[i] = 0;
            tbl_id[i] = 0;
            tbl_group[i] = 0;
            tbl_handle[i] = 0;
            tbl_stamp[i] = 0;
            tbl_tries[i] = 0;
            tbl_order[i] = 0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: everything disabled at reset values
        add_item(OP_REQUEST, 8'hFF, 32'hFFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF, 1);
        add_item(OP_CANCEL, 0, 32'hFFFF_FFFF, 0, 0);
        add_item(OP_UNUSED, 8'hFF, 0, 0, 1);
        drain();
        write_reg(REG_REQUEST_ENABLE, 16'hFFFF);
        write_reg(REG_CANCEL_ENABLE, 1);
        write_reg(REG_MAX_TRIES, 2);
        write_reg(REG_RETRY_DELAY, 16'hFFFF);
        // queueing, promotion with equal stamps, retry saturation, give-up
        add_item(OP_REQUEST, 8'hFF, 32'hA, 5, 0);
        add_item(OP_REQUEST, 8'hFF, 32'hB, 3, 0);
        add_item(OP_REQUEST, 8'hFF, 32'hC, 3, 0);
        add_item(OP_REQUEST, 8'hFF, 32'hA, 3, 0);
        add_item(OP_RESPONSE, 0, 32'hB, 63'h7FFF_FFFF_FFFF_FFF0, 1);
        add_item(OP_RESPONSE, 0, 32'hA, 63'h7FFF_FFFF_FFFF_FFF0, 1);
        add_item(OP_RESPONSE, 0, 32'hA, 9, 1);
        add_item(OP_RESPONSE, 0, 32'hA, 10, 1);
        add_item(OP_CANCEL, 0, 32'hB, 11, 0);
        add_item(OP_RESPONSE, 0, 32'hC, 12, 0);
        add_item(OP_RESPONSE, 0, 32'hDEAD, 12, 0);
        add_item(OP_CANCEL, 0, 32'hBEEF, 12, 0);
        for (int i = 0; i < 18; i++)
            add_item(OP_REQUEST, i[7:0], i, 63'(i), 0);
        drain();
        for (int i = 0; i < 16; i++)
            add_item(OP_RESPONSE, 0, i, 20, 0);
        drain();

        write_reg(REG_MAX_TRIES, 0);
        write_reg(REG_RETRY_DELAY, 0);
        random_phase(300, 4);
        drain();
        write_reg(REG_MAX_TRIES, 127);
        write_reg(REG_RETRY_DELAY, 3000);
        random_phase(350, 3);
        drain();
        write_reg(REG_CANCEL_ENABLE, 0);
        write_reg(REG_MAX_TRIES, 1);
        random_phase(250, 8);
        drain();
        write_reg(REG_REQUEST_ENABLE, 0);
        write_reg(REG_CANCEL_ENABLE, 1);
        random_phase(100, 2);
        drain();
        write_reg(REG_REQUEST_ENABLE, 1);
        write_reg(REG_MAX_TRIES, 4);
        write_reg(REG_RETRY_DELAY, 16'($urandom));
        random_phase(350, 2);
        while (pending_items.size() > 100)
            @(posedge clk);
        idle_off = 1;
        random_phase(150, 5);
        drain();

        $display("Ran %0d items through several config settings; %0d results, %0d issues.",
                 items_sent, results_seen, issues_seen);
        if (errors == 0)
            $display("** per_group_request_serializer_unit: PASSED **");
        else
            $display("** per_group_request_serializer_unit: FAILED **");
        $finish;
    end

endmodule

// File: sim.f
hdl/pgrs_pkg.sv
hdl/pgrs_table.sv
hdl/per_group_request_serializer_unit.sv
bench/tb_per_group_request_serializer_unit.sv
